FILE: sv/awbq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// awbq_pkg
// Shared types and constants of the A-weighting biquad filter: coefficient
// format, register indexes and coefficient reset values.
// ----------------------------------------------------------------------------
package awbq_pkg;

	// Coefficients are signed Q3.20 words
	localparam int unsigned COEF_BITS    = 24;
	localparam int unsigned CFG_IDX_BITS = 3;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_COEF_B0 = 3'd0,
		REG_COEF_B1 = 3'd1,
		REG_COEF_B2 = 3'd2,
		REG_COEF_A1 = 3'd3,
		REG_COEF_A2 = 3'd4
	} cfg_reg_t;

	typedef logic signed [COEF_BITS-1:0] coef_t;

	// A-weighting section coefficients after reset
	localparam coef_t COEF_B0_RST = 24'sd268165;
	localparam coef_t COEF_B1_RST = -24'sd536330;
	localparam coef_t COEF_B2_RST = 24'sd268165;
	localparam coef_t COEF_A1_RST = -24'sd1818992;
	localparam coef_t COEF_A2_RST = 24'sd803216;

endpackage

FILE: sv/awbq_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// awbq_in_if
// Sample stream into the filter: one audio sample and a block-start flag.
// ----------------------------------------------------------------------------
interface awbq_in_if #(
	parameter int unsigned SAMPLE_BITS = 24
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_in;
	logic                          block_start;

	modport source (output valid, output sample_in, output block_start, input ready);
	modport sink   (input valid, input sample_in, input block_start, output ready);
endinterface

FILE: sv/awbq_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// awbq_out_if
// Filtered sample stream out of the filter, with a clip flag.
// ----------------------------------------------------------------------------
interface awbq_out_if #(
	parameter int unsigned SAMPLE_BITS = 24
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_out;
	logic                          saturated;

	modport source (output valid, output sample_out, output saturated, input ready);
	modport sink   (input valid, input sample_out, input saturated, output ready);
endinterface

FILE: sv/a_weighting_biquad_filter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a_weighting_biquad_filter_unit
// Direct form I biquad set up for A-weighting. Five products are summed
// exactly, rounded half up, shifted down by COEF_FRAC_BITS and saturated.
// ----------------------------------------------------------------------------
//  channel   | dir | beat payload                        | handshake
//  audio     | in  | sample_in, block_start              | valid/ready
//  filtered  | out | sample_out, saturated               | valid/ready
//  cfg       | in  | cfg_wen, cfg_index, cfg_wdata       | write enable
//
// An accepted sample sits in the input register and lands in the output
// register; one sample per cycle is sustained while the output is not
// stalled. The pass from the input register through the five multipliers
// and the sum to the output register is combinational; the output history
// is written in the same edge so the next sample sees it.
// Reset restores the A-weighting coefficients and clears the history.
// A stalled output holds its beat; input is still taken while the input
// register is free or moving.
// ----------------------------------------------------------------------------
module a_weighting_biquad_filter_unit #(
	parameter int unsigned SAMPLE_BITS    = 24,
	parameter int unsigned COEF_FRAC_BITS = 20
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	awbq_in_if.sink                               audio,
	awbq_out_if.source                            filtered,
	input  logic                                  cfg_wen,
	input  logic [awbq_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [awbq_pkg::COEF_BITS-1:0]        cfg_wdata
);

	localparam int unsigned PROD_W = SAMPLE_BITS + awbq_pkg::COEF_BITS;
	localparam int unsigned ACC_W  = PROD_W + 3;

	localparam logic signed [ACC_W-1:0] SAT_MAX =
		{{(ACC_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] SAT_MIN =
		{{(ACC_W-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};
	localparam logic signed [ACC_W-1:0] ROUND_HALF =
		ACC_W'(1) << (COEF_FRAC_BITS - 1);

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;

	// coefficients
	awbq_pkg::coef_t coef_b0_q, coef_b1_q, coef_b2_q, coef_a1_q, coef_a2_q;

	// history
	sample_t prev_in_1_q, prev_in_2_q, prev_out_1_q, prev_out_2_q;

	// input register
	logic    valid_s1;
	sample_t sample_s1;
	logic    block_start_s1;

	// output register
	logic    out_valid_q;
	sample_t out_sample_q;
	logic    out_sat_q;

	logic    advance;
	sample_t x1, x2, y1, y2;
	logic signed [PROD_W-1:0] p_b0, p_b1, p_b2, p_a1, p_a2;
	logic signed [ACC_W-1:0]  acc, acc_rnd, acc_sh;
	sample_t y0;
	logic    sat;

	// write coefficient registers; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_b0_q <= awbq_pkg::COEF_B0_RST;
			coef_b1_q <= awbq_pkg::COEF_B1_RST;
			coef_b2_q <= awbq_pkg::COEF_B2_RST;
			coef_a1_q <= awbq_pkg::COEF_A1_RST;
			coef_a2_q <= awbq_pkg::COEF_A2_RST;
		end else if (cfg_wen) begin
			case (awbq_pkg::cfg_reg_t'(cfg_index))
				awbq_pkg::REG_COEF_B0: coef_b0_q <= cfg_wdata;
				awbq_pkg::REG_COEF_B1: coef_b1_q <= cfg_wdata;
				awbq_pkg::REG_COEF_B2: coef_b2_q <= cfg_wdata;
				awbq_pkg::REG_COEF_A1: coef_a1_q <= cfg_wdata;
				awbq_pkg::REG_COEF_A2: coef_a2_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// handshake: move the input beat when the output register is free
	assign advance        = valid_s1 && (!out_valid_q || filtered.ready);
	assign audio.ready    = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (audio.ready) begin
			valid_s1 <= audio.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (audio.valid && audio.ready) begin
			sample_s1      <= audio.sample_in;
			block_start_s1 <= audio.block_start;
		end
	end

	// history as seen by this sample, cleared at a block start
	assign x1 = block_start_s1 ? '0 : prev_in_1_q;
	assign x2 = block_start_s1 ? '0 : prev_in_2_q;
	assign y1 = block_start_s1 ? '0 : prev_out_1_q;
	assign y2 = block_start_s1 ? '0 : prev_out_2_q;

	// five products, exact sum, round half up, floor shift, clip
	always_comb begin
		p_b0    = PROD_W'(sample_s1) * PROD_W'(coef_b0_q);
		p_b1    = PROD_W'(x1) * PROD_W'(coef_b1_q);
		p_b2    = PROD_W'(x2) * PROD_W'(coef_b2_q);
		p_a1    = PROD_W'(y1) * PROD_W'(coef_a1_q);
		p_a2    = PROD_W'(y2) * PROD_W'(coef_a2_q);
		acc     = ACC_W'(p_b0) + ACC_W'(p_b1) + ACC_W'(p_b2)
		        - ACC_W'(p_a1) - ACC_W'(p_a2);
		acc_rnd = acc + ROUND_HALF;
		acc_sh  = acc_rnd >>> COEF_FRAC_BITS;
		if (acc_sh > SAT_MAX) begin
			y0  = SAT_MAX[SAMPLE_BITS-1:0];
			sat = 1'b1;
		end else if (acc_sh < SAT_MIN) begin
			y0  = SAT_MIN[SAMPLE_BITS-1:0];
			sat = 1'b1;
		end else begin
			y0  = acc_sh[SAMPLE_BITS-1:0];
			sat = 1'b0;
		end
	end

	// advance history with the beat that moves to the output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_in_1_q  <= '0;
			prev_in_2_q  <= '0;
			prev_out_1_q <= '0;
			prev_out_2_q <= '0;
		end else if (advance) begin
			prev_in_1_q  <= sample_s1;
			prev_in_2_q  <= x1;
			prev_out_1_q <= y0;
			prev_out_2_q <= y1;
		end
	end

	// output register; hold while the sink stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (filtered.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_sample_q <= y0;
			out_sat_q    <= sat;
		end
	end

	assign filtered.valid      = out_valid_q;
	assign filtered.sample_out = out_sample_q;
	assign filtered.saturated  = out_sat_q;

	// a clipped beat carries one of the two rail values
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_sat_q |->
			out_sample_q == SAT_MAX[SAMPLE_BITS-1:0] ||
			out_sample_q == SAT_MIN[SAMPLE_BITS-1:0])
		else $error("saturated beat is not at a rail");

	// the delivered sample is what entered the output history
	assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> prev_out_1_q == out_sample_q && prev_in_1_q == $past(sample_s1))
		else $error("history out of step with output");

	// a block start leaves no old input or output behind two deep
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && block_start_s1 |=> prev_in_2_q == '0 && prev_out_2_q == '0)
		else $error("block start did not clear history");

	// a stalled output beat is neither lost nor replaced
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !filtered.ready |=> out_valid_q && $stable(out_sample_q))
		else $error("stalled output beat changed");

endmodule
